@@ hdl/awu_pkg.sv @@
package awu_pkg;

  // Default store depth
  localparam int ELEMENTS_DEF = 4096;

  // Field widths
  localparam int IDX_W    = 12;
  localparam int DATA_W   = 32;
  localparam int CFG_W    = 24;
  localparam int MOM_W    = 48;
  localparam int NUM_W    = 56;
  localparam int ROOT_W   = 32;
  localparam int DEN_W    = 33;

  // Square root: 32 result bits, two per stage
  localparam int SQ_STEPS  = 2;
  localparam int SQ_STAGES = ROOT_W / SQ_STEPS;

  // Divider: 56 quotient bits, two per stage
  localparam int DV_STEPS  = 2;
  localparam int DV_STAGES = NUM_W / DV_STEPS;

  // Register reset values
  localparam logic [23:0] LR_RESET  = 24'd16777;
  localparam logic [15:0] B1_RESET  = 16'd58982;
  localparam logic [15:0] B2_RESET  = 16'd65470;
  localparam logic [23:0] EPS_RESET = 24'd1;
  localparam logic [15:0] WD_RESET  = 16'd0;

  typedef enum logic [2:0] {
    REG_LEARNING_RATE = 3'd0,
    REG_BETA_FIRST    = 3'd1,
    REG_BETA_SECOND   = 3'd2,
    REG_EPSILON       = 3'd3,
    REG_WEIGHT_DECAY  = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } mem_state_t;

  // One store entry: first moment, second moment, running maximum
  typedef struct packed {
    logic signed [DATA_W-1:0] m;
    logic [MOM_W-1:0]         v;
    logic [MOM_W-1:0]         vmax;
  } moment_t;

  // Item context carried alongside the root pipeline
  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] w;
    logic                     mneg;
    logic                     mzero;
    logic [NUM_W-1:0]         num;
  } sq_side_t;

  // Item context carried alongside the divider
  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] w;
    logic                     mneg;
    logic                     mzero;
    logic                     dzero;
  } dv_side_t;

endpackage

@@ hdl/awu_moment_mem.sv @@
module awu_moment_mem import awu_pkg::*; #(
  parameter int ELEMENTS = ELEMENTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  output logic                 busy,
  input  logic                 rd_en,
  input  logic [((ELEMENTS > 1) ? $clog2(ELEMENTS) : 1)-1:0] rd_addr,
  output moment_t              rd_data,
  input  logic                 wr_en,
  input  logic [((ELEMENTS > 1) ? $clog2(ELEMENTS) : 1)-1:0] wr_addr,
  input  moment_t              wr_data
);

  localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

  moment_t    mem [ELEMENTS];
  mem_state_t state, state_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic          we;
  logic [AW-1:0] wa;
  moment_t       wd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
  end

  // Sweep every entry to zero after reset, then hand the port to the pipeline
  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    busy          = 1'b0;
    we            = wr_en;
    wa            = wr_addr;
    wd            = wr_data;
    case (state)
      ST_CLEAR: begin
        busy          = 1'b1;
        we            = 1'b1;
        wa            = clr_addr;
        wd            = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == AW'(ELEMENTS - 1)) begin
          state_next    = ST_RUN;
          clr_addr_next = '0;
        end
      end
      ST_RUN: begin
        busy = 1'b0;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/awu_sqrt_pipe.sv @@
module awu_sqrt_pipe import awu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              src_valid,
  input  logic [63:0]       src_x,
  input  sq_side_t          src_side,
  output logic              dst_valid,
  output logic [ROOT_W-1:0] dst_root,
  output sq_side_t          dst_side
);

  logic              vld_q  [SQ_STAGES];
  logic [35:0]       rem_q  [SQ_STAGES];
  logic [ROOT_W-1:0] root_q [SQ_STAGES];
  logic [63:0]       x_q    [SQ_STAGES];
  sq_side_t          side_q [SQ_STAGES];

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_st
    logic              v_i;
    logic [35:0]       rem_i, rem, trial;
    logic [ROOT_W-1:0] root_i, root;
    logic [63:0]       x_i, xs;
    sq_side_t          side_i;

    if (s == 0) begin : g_first
      assign v_i    = src_valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign x_i    = src_x;
      assign side_i = src_side;
    end else begin : g_next
      assign v_i    = vld_q[s-1];
      assign rem_i  = rem_q[s-1];
      assign root_i = root_q[s-1];
      assign x_i    = x_q[s-1];
      assign side_i = side_q[s-1];
    end

    // Two digit-by-digit root steps
    always_comb begin
      rem   = rem_i;
      root  = root_i;
      xs    = x_i;
      trial = '0;
      for (int j = 0; j < SQ_STEPS; j++) begin
        rem   = {rem[33:0], xs[63:62]};
        xs    = {xs[61:0], 2'b00};
        trial = {2'b00, root, 2'b01};
        if (rem >= trial) begin
          rem  = rem - trial;
          root = {root[ROOT_W-2:0], 1'b1};
        end else begin
          root = {root[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (advance) begin
        vld_q[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem_q[s]  <= rem;
        root_q[s] <= root;
        x_q[s]    <= xs;
        side_q[s] <= side_i;
      end
    end
  end

  assign dst_valid = vld_q[SQ_STAGES-1];
  assign dst_root  = root_q[SQ_STAGES-1];
  assign dst_side  = side_q[SQ_STAGES-1];

endmodule

@@ hdl/awu_div_pipe.sv @@
module awu_div_pipe import awu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             src_valid,
  input  logic [NUM_W-1:0] src_num,
  input  logic [DEN_W-1:0] src_den,
  input  dv_side_t         src_side,
  output logic             dst_valid,
  output logic [NUM_W-1:0] dst_quot,
  output dv_side_t         dst_side
);

  logic             vld_q  [DV_STAGES];
  logic [34:0]      rem_q  [DV_STAGES];
  logic [NUM_W-1:0] n_q    [DV_STAGES];
  logic [NUM_W-1:0] q_q    [DV_STAGES];
  logic [DEN_W-1:0] d_q    [DV_STAGES];
  dv_side_t         side_q [DV_STAGES];

  for (genvar s = 0; s < DV_STAGES; s++) begin : g_st
    logic             v_i;
    logic [34:0]      rem_i, rem;
    logic [NUM_W-1:0] n_i, ns, q_i, q;
    logic [DEN_W-1:0] d_i;
    dv_side_t         side_i;

    if (s == 0) begin : g_first
      assign v_i    = src_valid;
      assign rem_i  = '0;
      assign n_i    = src_num;
      assign q_i    = '0;
      assign d_i    = src_den;
      assign side_i = src_side;
    end else begin : g_next
      assign v_i    = vld_q[s-1];
      assign rem_i  = rem_q[s-1];
      assign n_i    = n_q[s-1];
      assign q_i    = q_q[s-1];
      assign d_i    = d_q[s-1];
      assign side_i = side_q[s-1];
    end

    // Two restoring division steps
    always_comb begin
      rem = rem_i;
      ns  = n_i;
      q   = q_i;
      for (int j = 0; j < DV_STEPS; j++) begin
        rem = {rem[33:0], ns[NUM_W-1]};
        ns  = {ns[NUM_W-2:0], 1'b0};
        if (rem >= {2'b00, d_i}) begin
          rem = rem - {2'b00, d_i};
          q   = {q[NUM_W-2:0], 1'b1};
        end else begin
          q   = {q[NUM_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (advance) begin
        vld_q[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem_q[s]  <= rem;
        n_q[s]    <= ns;
        q_q[s]    <= q;
        d_q[s]    <= d_i;
        side_q[s] <= side_i;
      end
    end
  end

  assign dst_valid = vld_q[DV_STAGES-1];
  assign dst_quot  = q_q[DV_STAGES-1];
  assign dst_side  = side_q[DV_STAGES-1];

endmodule

@@ hdl/amsgrad_weight_update.sv @@
// AMSgrad weight update without bias correction, one weight element per transfer.
// Item channel: item_valid / item_stall carries element_index, gradient and weight
// (signed Q8.24). Result channel: result_valid / result_stall carries result_index
// and new_weight, the decayed weight minus lr * m / (sqrt(vmax) + epsilon),
// saturated to signed Q8.24. Exactly one result per item, in order.
// Configuration: cfg_write with cfg_index selects learning_rate, beta_first,
// beta_second, epsilon, weight_decay (indexes 0..4); other indexes are dropped.
// Write registers only while no item is in flight.
// From transfer to result_valid an item passes the capture register (stage A),
// the product and moment read-modify-write registers (stages B, C and D), the
// root pipeline (two bits a stage), the divider (two quotient bits a stage) and
// one output register.
// Throughput is one item per cycle unless the pipeline is held or the store is
// being swept; the moment store is a single-port-write, single-read memory,
// with the previous item's write forwarded when both hit the same element back
// to back. After reset the store is swept to zero, one entry a cycle;
// item_stall stays high during the sweep.
// When result_stall holds a waiting result, the whole pipeline holds and
// item_stall rises; no result is lost or repeated.
module amsgrad_weight_update import awu_pkg::*; #(
  parameter int ELEMENTS = ELEMENTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [2:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [IDX_W-1:0]         element_index,
  input  logic signed [DATA_W-1:0] gradient,
  input  logic signed [DATA_W-1:0] weight,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [IDX_W-1:0]         result_index,
  output logic signed [DATA_W-1:0] new_weight
);

  localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int RED_SPLIT = 6;
  localparam logic [32:0] EL = 33'(ELEMENTS);

  // Configuration registers
  logic [23:0] learning_rate, epsilon;
  logic [15:0] beta_first, beta_second, weight_decay;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= LR_RESET;
      beta_first    <= B1_RESET;
      beta_second   <= B2_RESET;
      epsilon       <= EPS_RESET;
      weight_decay  <= WD_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_LEARNING_RATE: learning_rate <= cfg_data;
        REG_BETA_FIRST:    beta_first    <= cfg_data[15:0];
        REG_BETA_SECOND:   beta_second   <= cfg_data[15:0];
        REG_EPSILON:       epsilon       <= cfg_data;
        REG_WEIGHT_DECAY:  weight_decay  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves together unless a finished result waits
  logic adv, busy;
  assign adv        = !result_valid || !result_stall;
  assign item_stall = !adv || busy;

  // Stage A: capture item, first half of the index reduction
  logic                     a_valid;
  logic [IDX_W-1:0]         a_idx, a_r, red_a;
  logic signed [DATA_W-1:0] a_g, a_w;

  always_comb begin
    red_a = element_index;
    for (int k = IDX_W - 1; k >= RED_SPLIT; k--) begin
      if ({21'b0, red_a} >= (EL << k)) begin
        red_a = red_a - IDX_W'(EL << k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= item_valid && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_idx <= element_index;
      a_r   <= red_a;
      a_g   <= gradient;
      a_w   <= weight;
    end
  end

  // Stage B: gradient square, decay product, first-moment input term
  logic [DATA_W-1:0]        gabs;
  logic [63:0]              gsq_full;
  logic signed [48:0]       wprod;
  logic signed [49:0]       c1;
  logic [IDX_W-1:0]         red_b;
  logic                     b_valid;
  logic [IDX_W-1:0]         b_idx;
  logic [AW-1:0]            b_e;
  logic [MOM_W-1:0]         b_gsq;
  logic signed [48:0]       b_wprod;
  logic signed [49:0]       b_c1;
  logic signed [DATA_W-1:0] b_w;

  assign gabs     = a_g[DATA_W-1] ? DATA_W'(-a_g) : DATA_W'(a_g);
  assign gsq_full = 64'(gabs) * 64'(gabs);
  assign wprod    = $signed({1'b0, weight_decay}) * a_w;
  assign c1       = $signed({1'b0, 17'(17'h10000 - {1'b0, beta_first})}) * a_g;

  always_comb begin
    red_b = a_r;
    for (int k = RED_SPLIT - 1; k >= 0; k--) begin
      if ({21'b0, red_b} >= (EL << k)) begin
        red_b = red_b - IDX_W'(EL << k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_idx   <= a_idx;
      b_e     <= AW'(red_b);
      b_gsq   <= gsq_full[63:16];
      b_wprod <= wprod;
      b_c1    <= c1;
      b_w     <= a_w;
    end
  end

  // Stage C: second-moment input term, decayed weight; store read issued
  logic [63:0]              c2;
  logic signed [DATA_W-1:0] wdec;
  logic                     c_valid;
  logic [IDX_W-1:0]         c_idx;
  logic [AW-1:0]            c_e;
  logic signed [49:0]       c_c1;
  logic [63:0]              c_c2;
  logic signed [DATA_W-1:0] c_w;

  assign c2   = 64'(17'(17'h10000 - {1'b0, beta_second})) * 64'(b_gsq);
  assign wdec = b_w - DATA_W'(b_wprod >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_idx <= b_idx;
      c_e   <= b_e;
      c_c1  <= b_c1;
      c_c2  <= c2;
      c_w   <= wdec;
    end
  end

  // Moment update with forwarding from the item just written, held in the D registers
  moment_t                  rd_data, old, upd;
  logic signed [50:0]       msum;
  logic [65:0]              vsum;
  logic                     d_valid;
  logic [IDX_W-1:0]         d_idx;
  logic [AW-1:0]            d_e;
  moment_t                  d_mom;
  logic signed [DATA_W-1:0] d_w;

  always_comb begin
    old = (d_valid && d_e == c_e) ? d_mom : rd_data;
    msum = $signed({1'b0, beta_first}) * old.m + c_c1;
    vsum = 66'(beta_second) * 66'(old.v) + 66'(c_c2);
    upd.m    = msum[47:16];
    upd.v    = vsum[63:16];
    upd.vmax = (upd.v > old.vmax) ? upd.v : old.vmax;
  end

  awu_moment_mem #(
    .ELEMENTS(ELEMENTS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .busy    (busy),
    .rd_en   (adv),
    .rd_addr (b_e),
    .rd_data (rd_data),
    .wr_en   (adv && c_valid),
    .wr_addr (c_e),
    .wr_data (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_idx <= c_idx;
      d_e   <= c_e;
      d_mom <= upd;
      d_w   <= c_w;
    end
  end

  // Stage D: numerator lr * |m|, root of vmax * 2^16
  logic [DATA_W-1:0] mabs;
  sq_side_t          sq_in, sq_out;
  logic              sq_valid;
  logic [ROOT_W-1:0] root;

  assign mabs = d_mom.m[DATA_W-1] ? DATA_W'(-d_mom.m) : DATA_W'(d_mom.m);

  always_comb begin
    sq_in.idx   = d_idx;
    sq_in.w     = d_w;
    sq_in.mneg  = d_mom.m[DATA_W-1];
    sq_in.mzero = (d_mom.m == '0);
    sq_in.num   = NUM_W'(learning_rate) * NUM_W'(mabs);
  end

  awu_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .advance   (adv),
    .src_valid (d_valid),
    .src_x     ({d_mom.vmax, 16'b0}),
    .src_side  (sq_in),
    .dst_valid (sq_valid),
    .dst_root  (root),
    .dst_side  (sq_out)
  );

  // Divider: step magnitude = num / (root + epsilon)
  logic [DEN_W-1:0] den;
  dv_side_t         dv_in, dv_out;
  logic             dv_valid;
  logic [NUM_W-1:0] quot;

  assign den = DEN_W'(root) + DEN_W'(epsilon);

  always_comb begin
    dv_in.idx   = sq_out.idx;
    dv_in.w     = sq_out.w;
    dv_in.mneg  = sq_out.mneg;
    dv_in.mzero = sq_out.mzero;
    dv_in.dzero = (den == '0);
  end

  awu_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .advance   (adv),
    .src_valid (sq_valid),
    .src_num   (sq_out.num),
    .src_den   (den),
    .src_side  (dv_in),
    .dst_valid (dv_valid),
    .dst_quot  (quot),
    .dst_side  (dv_out)
  );

  // Output register: apply the step and saturate
  logic signed [57:0]       wide, sum;
  logic signed [DATA_W-1:0] res;

  always_comb begin
    wide = 58'(dv_out.w);
    sum  = dv_out.mneg ? (wide + $signed({2'b00, quot}))
                       : (wide - $signed({2'b00, quot}));
    if (dv_out.mzero || learning_rate == '0) begin
      res = dv_out.w;
    end else if (dv_out.dzero) begin
      res = dv_out.mneg ? {1'b0, {(DATA_W-1){1'b1}}} : {1'b1, {(DATA_W-1){1'b0}}};
    end else if (sum[57:DATA_W-1] != {(58-DATA_W+1){sum[57]}}) begin
      res = sum[57] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      res = sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_index <= dv_out.idx;
      new_weight   <= res;
    end
  end

`ifndef SYNTH
  // No item enters while the store is being swept
  a_no_intake_clear: assert property (@(posedge clk) disable iff (rst)
    busy |-> item_stall) else $error("item taken during store clear");

  // Nothing reaches the read-modify-write stage during the sweep
  a_no_rmw_clear: assert property (@(posedge clk) disable iff (rst)
    busy |-> !c_valid) else $error("moment update during store clear");

  // A written entry is held in the forwarding stage for the next item
  a_fwd_track: assert property (@(posedge clk) disable iff (rst)
    (c_valid && adv) |=> (d_valid && d_e == $past(c_e)))
    else $error("forwarding stage lost the written entry");

  // A held pipeline does not move its first stage
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(a_valid)) else $error("stage moved while held");
`endif

endmodule

@@ sim/amsgrad_weight_update_checker.sv @@
module amsgrad_weight_update_checker import awu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [2:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     item_valid,
  input  logic                     item_stall,
  input  logic [IDX_W-1:0]         element_index,
  input  logic signed [DATA_W-1:0] gradient,
  input  logic signed [DATA_W-1:0] weight,
  input  logic                     result_valid,
  input  logic                     result_stall,
  input  logic [IDX_W-1:0]         result_index,
  input  logic signed [DATA_W-1:0] new_weight,
  output int                       fail_count,
  output int                       pending
);

  typedef struct {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] w;
  } upd_t;

  upd_t updated_weights[$];

  logic [23:0] lr_q, eps_q;
  logic [15:0] b1_q, b2_q, wd_q;
  logic signed [31:0] m_store[ELEMENTS_DEF];
  logic [47:0] v_store[ELEMENTS_DEF];
  logic [47:0] vmax_store[ELEMENTS_DEF];

  assign pending = updated_weights.size();

  function automatic longint floor_sh16(longint x);
    return x >>> 16;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Advance the moment state of one element and return its updated weight.
  function automatic logic signed [31:0] amsgrad_step(logic [IDX_W-1:0] idx,
      logic signed [31:0] g_in, logic signed [31:0] w_in);
    int e;
    longint g, w, m, res;
    logic [63:0] ag, gsq, v, vmax, d, num, q;
    e = idx % ELEMENTS_DEF;
    g = g_in;
    w = w_in;
    if (wd_q != 0) w = w - floor_sh16(longint'(wd_q) * w);
    m = floor_sh16(longint'(b1_q) * longint'(m_store[e]) + longint'(65536 - b1_q) * g);
    m_store[e] = m[31:0];
    ag = (g < 0) ? -g : g;
    gsq = (ag * ag) >> 16;
    v = ((64'(b2_q) * v_store[e]) + 64'(65536 - b2_q) * gsq) >> 16;
    v = v & 64'hFFFF_FFFF_FFFF;
    v_store[e] = v[47:0];
    vmax = vmax_store[e];
    if (v > vmax) vmax = v;
    vmax_store[e] = vmax[47:0];
    d = int_sqrt(vmax << 16) + 64'(eps_q);
    if (m == 0 || lr_q == 0) begin
      res = w;
    end else if (d == 0) begin
      res = (m > 0) ? -64'sh8000_0000 : 64'sh7FFF_FFFF;
    end else begin
      num = 64'(lr_q) * ((m < 0) ? -m : m);
      q = num / d;
      res = (m > 0) ? w - longint'(q) : w + longint'(q);
      if (res > 64'sh7FFF_FFFF) res = 64'sh7FFF_FFFF;
      if (res < -64'sh8000_0000) res = -64'sh8000_0000;
    end
    return res[31:0];
  endfunction

  always @(posedge clk) begin
    upd_t exp_r;
    int errs;
    errs = 0;
    if (rst) begin
      lr_q <= LR_RESET;
      b1_q <= B1_RESET;
      b2_q <= B2_RESET;
      eps_q <= EPS_RESET;
      wd_q <= WD_RESET;
      fail_count <= 0;
      updated_weights.delete();
      for (int i = 0; i < ELEMENTS_DEF; i++) begin
        m_store[i] = 0;
        v_store[i] = 0;
        vmax_store[i] = 0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_LEARNING_RATE: lr_q <= cfg_data;
          REG_BETA_FIRST:    b1_q <= cfg_data[15:0];
          REG_BETA_SECOND:   b2_q <= cfg_data[15:0];
          REG_EPSILON:       eps_q <= cfg_data;
          REG_WEIGHT_DECAY:  wd_q <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (updated_weights.size() == 0) begin
          $error("unexpected result index %0d weight %0d", result_index, new_weight);
          errs++;
        end else begin
          exp_r = updated_weights.pop_front();
          if (result_index !== exp_r.idx) begin
            $error("result_index expected %0d actual %0d", exp_r.idx, result_index);
            errs++;
          end
          if (new_weight !== exp_r.w) begin
            $error("new_weight expected %0d actual %0d", exp_r.w, new_weight);
            errs++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        exp_r.idx = element_index;
        exp_r.w = amsgrad_step(element_index, gradient, weight);
        updated_weights.push_back(exp_r);
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

@@ sim/amsgrad_weight_update_tb.sv @@
module amsgrad_weight_update_tb import awu_pkg::*;;

  logic clk, rst;
  logic cfg_write;
  logic [2:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic item_valid, item_stall;
  logic [IDX_W-1:0] element_index;
  logic signed [DATA_W-1:0] gradient, weight;
  logic result_valid, result_stall;
  logic [IDX_W-1:0] result_index;
  logic signed [DATA_W-1:0] new_weight;
  int fail_count, pending;

  // Idle percentages for sender and receiver, set per phase.
  int send_idle_pct, recv_stall_pct;
  // Long receiver hold-off, counted down in its own process.
  int hold_cycles;
  longint cycle_count;
  // Item transfer seen at the last rising edge.
  logic in_taken;

  amsgrad_weight_update dut (.*);

  amsgrad_weight_update_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Abort on a runaway run: the sweep, the pipeline latency and heavy stalls all fit well below.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    in_taken <= item_valid && !item_stall;
  end

  // Receiver: random stalls, or a forced long hold-off.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      result_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Present one item and hold it until the transfer happens.
  task automatic send_item(logic [IDX_W-1:0] idx, logic [31:0] g, logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    element_index <= idx;
    gradient <= g;
    weight <= w;
    @(negedge clk);
    while (!in_taken) @(negedge clk);
  endtask

  // Drain all results, then let the pipeline settle before touching registers.
  task automatic drain;
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly reuse a small set of elements so the moments build up history.
  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(9) < 7) return IDX_W'($urandom_range(15));
    return IDX_W'($urandom);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(1023)) - 32'd512;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_items(int count);
    for (int i = 0; i < count; i++) send_item(pick_index(), pick_value(), pick_value());
  endtask

  initial begin
    cycle_count = 0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_valid = 1'b0;
    element_index = '0;
    gradient = '0;
    weight = '0;
    result_stall = 1'b0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes at reset settings, repeated elements, high index.
    send_item(12'd0, 32'h0000_0000, 32'h0000_0000);
    send_item(12'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(12'd0, 32'h8000_0000, 32'h8000_0000);
    send_item(12'd4095, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(12'd4095, 32'h0100_0000, 32'hFF00_0000);
    send_item(12'd7, 32'hFFFF_FFFF, 32'h0000_0001);
    send_item(12'd7, 32'h0000_0001, 32'hFFFF_FFFF);
    drain();

    // Zero denominator: epsilon zero with an element whose maximum is still zero.
    write_reg(REG_EPSILON, 24'd0);
    write_reg(REG_LEARNING_RATE, 24'hFFFFFF);
    write_reg(REG_WEIGHT_DECAY, 24'h00FFFF);
    write_reg(REG_BETA_FIRST, 24'd0);
    write_reg(REG_BETA_SECOND, 24'h00FFFF);
    cfg_index <= 3'd7;
    cfg_write <= 1'b1;
    cfg_data <= 24'h123456;
    @(negedge clk);
    cfg_write <= 1'b0;
    send_item(12'd100, 32'h0000_0001, 32'h0000_1000);
    send_item(12'd101, 32'hFFFF_FFFF, 32'hFFFF_0000);
    send_item(12'd102, 32'h0000_0000, 32'h1234_5678);
    send_item(12'd103, 32'h0000_8000, 32'h7FFF_FFFF);
    send_item(12'd104, 32'h8000_0000, 32'h8000_0000);
    drain();
    write_reg(REG_LEARNING_RATE, 24'd0);
    write_reg(REG_BETA_FIRST, 24'h00FFFF);
    write_reg(REG_BETA_SECOND, 24'd0);
    send_item(12'd5, 32'h7FFF_FFFF, 32'h4000_0000);
    send_item(12'd5, 32'h8000_0000, 32'hC000_0000);
    drain();

    // Random phases over several register settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        3: begin send_idle_pct = 11; recv_stall_pct = 11; end
        default: begin send_idle_pct = $urandom_range(30); recv_stall_pct = $urandom_range(30); end
      endcase
      write_reg(REG_LEARNING_RATE,
                (ph == 0) ? LR_RESET : CFG_W'($urandom_range(24'hFFFFFF)));
      write_reg(REG_BETA_FIRST, CFG_W'((ph == 1) ? 16'd0 : 16'($urandom)));
      write_reg(REG_BETA_SECOND, CFG_W'((ph == 2) ? 16'hFFFF : 16'($urandom)));
      write_reg(REG_EPSILON, (ph == 3) ? 24'hFFFFFF : CFG_W'($urandom_range(255)));
      write_reg(REG_WEIGHT_DECAY, CFG_W'((ph == 4) ? 16'd0 : 16'($urandom)));
      if (ph == 5) begin
        // Hold the receiver off long enough for the pipeline to fill and back up.
        hold_cycles = 200;
        random_items(150);
      end else begin
        random_items(300);
      end
      drain();
    end

    repeat (60) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ amsgrad_weight_update.f @@
hdl/awu_pkg.sv
hdl/awu_moment_mem.sv
hdl/awu_sqrt_pipe.sv
hdl/awu_div_pipe.sv
hdl/amsgrad_weight_update.sv
sim/amsgrad_weight_update_checker.sv
sim/amsgrad_weight_update_tb.sv
